// ===== hdl/lprs_pkg.sv =====
// Shared types, constants and the prefix mask function for the route select unit.
`timescale 1ns / 1ps
`default_nettype none

package lprs_pkg;

    // Table geometry
    localparam int ROUTE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(ROUTE_ENTRIES);
    localparam int ADDR_W        = 128;

    // Prefix limits and meta code layout
    localparam logic [7:0] V4_CODE_BASE  = 8'd129;
    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Table write request
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic              wr_valid;
        logic [7:0]        wr_code;
        logic [ADDR_W-1:0] wr_addr;
    } tbl_wr_t;

    // Table read request
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } tbl_rd_t;

    // Table read response, registered: valid in the cycle after the request
    typedef struct packed {
        logic              vld;
        logic [7:0]        code;
        logic [ADDR_W-1:0] addr;
    } tbl_rsp_t;

    // Lookup result
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [7:0]       prefix;
    } lprs_res_t;

    // Keeps the top plen bits of the family's address span
    function automatic logic [ADDR_W-1:0] route_mask(input logic v6, input logic [7:0] plen);
        logic [ADDR_W-1:0] m6;
        logic [31:0]       m4;
        m6 = ~({ADDR_W{1'b1}} >> plen);
        m4 = ~({32{1'b1}} >> plen);
        return v6 ? m6 : {{(ADDR_W-32){1'b0}}, m4};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lprs_table.sv =====
// Route table storage: address and code memories plus per-entry valid flops.
`timescale 1ns / 1ps
`default_nettype none

module lprs_table
    import lprs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_wr_t  wr,
    input  wire tbl_rd_t  rd,
    output tbl_rsp_t      rsp
);

    logic [ADDR_W-1:0] addr_mem [ROUTE_ENTRIES];
    logic [7:0]        code_mem [ROUTE_ENTRIES];
    logic              valid_reg [ROUTE_ENTRIES];

    logic [ADDR_W-1:0] rd_addr_reg;
    logic [7:0]        rd_code_reg;
    logic              rd_vld_reg;

    // Memory write on store, registered read
    always_ff @(posedge clk)
    begin
        if (wr.wr_en && wr.wr_valid)
        begin
            addr_mem[wr.wr_idx] <= wr.wr_addr;
            code_mem[wr.wr_idx] <= wr.wr_code;
        end
        if (rd.rd_en)
        begin
            rd_addr_reg <= addr_mem[rd.rd_idx];
            rd_code_reg <= code_mem[rd.rd_idx];
        end
    end

    // Valid bits: set on store, cleared on removal or reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUTE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.wr_en)
            begin
                valid_reg[wr.wr_idx] <= wr.wr_valid;
            end
            if (rd.rd_en)
            begin
                rd_vld_reg <= valid_reg[rd.rd_idx];
            end
        end
    end

    assign rsp.vld  = rd_vld_reg;
    assign rsp.code = rd_code_reg;
    assign rsp.addr = rd_addr_reg;

`ifndef SYNTHESIS
    // Writes land only while no scan reads the table
    assert property (@(posedge clk) disable iff (!rst_n) !(wr.wr_en && rd.rd_en))
        else $error("table write during scan read");

    // A write takes effect on the addressed valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.wr_en |=> valid_reg[$past(wr.wr_idx)] == $past(wr.wr_valid))
        else $error("valid bit not updated by write");
`endif

endmodule

`default_nettype wire

// ===== hdl/lprs_scan.sv =====
// Lookup sequencer: walks the table, masks the query per entry and keeps the best match.
`timescale 1ns / 1ps
`default_nettype none

module lprs_scan
    import lprs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              q_v6,
    input  wire logic [ADDR_W-1:0] q_addr,
    input  wire tbl_rsp_t          rsp,
    input  wire logic              slot_free,
    output tbl_rd_t                rd,
    output logic                   busy,
    output logic                   res_valid,
    output lprs_res_t              res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic              qv6_reg;
    logic [ADDR_W-1:0] qaddr_reg;

    // Stage 1: read issued, data arrives next cycle
    logic              s1_reg;
    logic [IDX_W-1:0]  s1_idx_reg;

    // Stage 2: decoded entry with its mask
    logic              s2_vld_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic              s2_elig_reg;
    logic [7:0]        s2_prefix_reg;
    logic [ADDR_W-1:0] s2_mask_reg;
    logic [ADDR_W-1:0] s2_addr_reg;

    // Best match so far
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [7:0]        best_p_reg;

    logic              e_v6;
    logic [7:0]        e_p;
    logic              e_in_range;
    logic              e_elig;
    logic              s2_match;
    logic              s2_take;

    // Decode the entry code from the table response
    always_comb
    begin
        e_v6       = rsp.code < V4_CODE_BASE;
        e_p        = e_v6 ? rsp.code : rsp.code - V4_CODE_BASE;
        e_in_range = e_v6 ? (e_p <= V6_MAX_PREFIX) : (e_p <= V4_MAX_PREFIX);
        e_elig     = rsp.vld && (e_v6 == qv6_reg) && e_in_range;
    end

    // Compare the masked query against the stored prefix
    assign s2_match = (qaddr_reg & s2_mask_reg) == s2_addr_reg;
    assign s2_take  = s2_vld_reg && s2_elig_reg && s2_match &&
                      (!found_reg || (s2_prefix_reg > best_p_reg));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_W'(ROUTE_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg && !s2_vld_reg)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd.rd_en  = (state_reg == ST_SCAN);
    assign rd.rd_idx = cnt_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            s1_reg     <= 1'b0;
            s2_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_reg     <= rd.rd_en;
            s2_vld_reg <= s1_reg;
            if (start)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (rd.rd_en)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (s2_take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qv6_reg      <= q_v6;
            qaddr_reg    <= q_addr;
            best_idx_reg <= '0;
            best_p_reg   <= '0;
        end
        else if (s2_take)
        begin
            best_idx_reg <= s2_idx_reg;
            best_p_reg   <= s2_prefix_reg;
        end
        s1_idx_reg    <= cnt_reg;
        s2_idx_reg    <= s1_idx_reg;
        s2_elig_reg   <= e_elig;
        s2_prefix_reg <= e_p;
        s2_mask_reg   <= route_mask(qv6_reg, e_p);
        s2_addr_reg   <= rsp.addr;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign res_valid  = (state_reg == ST_HOLD);
    assign res.found  = found_reg;
    assign res.idx    = found_reg ? best_idx_reg : '0;
    assign res.prefix = found_reg ? best_p_reg : '0;

`ifndef SYNTHESIS
    // A lookup only starts from idle
    assert property (@(posedge clk) disable iff (!rst_n) start |-> state_reg == ST_IDLE)
        else $error("lookup started while busy");

    // The pipeline is empty once a result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!s1_reg && !s2_vld_reg && !rd.rd_en))
        else $error("result offered with scan in flight");
`endif

endmodule

`default_nettype wire

// ===== hdl/longest_prefix_route_select_unit.sv =====
// Top level of the longest-prefix route select unit: input decode, table, scan, output register.
//
//   Channel   Signals                                     Direction
//   input     in_valid/in_ready, command..address_low     into block
//   output    out_valid/out_ready, found/best_index/...   out of block
//
// A write transaction updates the table in the cycle it is accepted; its
// all-zero result is loaded into the output register at once.
// A lookup walks all 64 entries through the one-read-port table memory,
// one per cycle, then drains the read and compare pipeline (stage 1,
// stage 2, best match) and loads the output register once it is free.
// Reset clears all valid bits at once; no clearing pass is needed.
// Input stalls while a lookup runs, or for a write while the output is held.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_select_unit
    import lprs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [5:0]  entry_index,
    input  wire logic        entry_valid,
    input  wire logic        is_ipv6,
    input  wire logic [7:0]  prefix_length,
    input  wire logic [63:0] address_high,
    input  wire logic [63:0] address_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [5:0]       best_index,
    output logic [7:0]       best_prefix
);

    tbl_wr_t   wr;
    tbl_rd_t   rd;
    tbl_rsp_t  rsp;
    lprs_res_t res;

    logic       busy;
    logic       res_valid;
    logic       slot_free;
    logic       accept;
    logic       wr_accept;
    logic [7:0] plen_sat;

    logic       out_valid_reg;
    logic       found_reg;
    logic [5:0] best_index_reg;
    logic [7:0] best_prefix_reg;

    // Handshake
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = !busy && (slot_free || (command == CMD_LOOKUP));
    assign accept    = in_valid && in_ready;
    assign wr_accept = accept && (command == CMD_WRITE);

    // Saturate the prefix to the family limit
    always_comb
    begin
        if (is_ipv6)
        begin
            plen_sat = (prefix_length > V6_MAX_PREFIX) ? V6_MAX_PREFIX : prefix_length;
        end
        else
        begin
            plen_sat = (prefix_length > V4_MAX_PREFIX) ? V4_MAX_PREFIX : prefix_length;
        end
    end

    // Table write request
    assign wr.wr_en    = wr_accept && (32'(entry_index) < ROUTE_ENTRIES);
    assign wr.wr_idx   = IDX_W'(entry_index);
    assign wr.wr_valid = entry_valid;
    assign wr.wr_code  = is_ipv6 ? plen_sat : plen_sat + V4_CODE_BASE;
    assign wr.wr_addr  = {address_high, address_low} & route_mask(is_ipv6, plen_sat);

    lprs_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rsp   (rsp)
    );

    lprs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (command == CMD_LOOKUP)),
        .q_v6      (is_ipv6),
        .q_addr    ({address_high, address_low}),
        .rsp       (rsp),
        .slot_free (slot_free),
        .rd        (rd),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wr_accept || (res_valid && slot_free))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_accept)
        begin
            found_reg       <= 1'b0;
            best_index_reg  <= '0;
            best_prefix_reg <= '0;
        end
        else if (res_valid && slot_free)
        begin
            found_reg       <= res.found;
            best_index_reg  <= 6'(res.idx);
            best_prefix_reg <= res.prefix;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign best_index  = best_index_reg;
    assign best_prefix = best_prefix_reg;

endmodule

`default_nettype wire
